// ----- src/tdaq_pkg.sv -----
// Shared codes for the tick deadline alarm queues.
package tdaq_pkg;
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [1:0] FUNC_WATCH  = 2'd2;
    localparam logic [1:0] FUNC_UPTIME = 2'd3;

    localparam logic [2:0] KIND_WATCH_FIRED  = 3'd0;
    localparam logic [2:0] KIND_SIGNAL_FIRED = 3'd1;
    localparam logic [2:0] KIND_TICK_DONE    = 3'd2;
    localparam logic [2:0] KIND_SET_OK       = 3'd3;
    localparam logic [2:0] KIND_UPTIME       = 3'd4;
    localparam logic [2:0] KIND_FULL         = 3'd5;

    localparam logic [9:0] TPS_RESET = 10'd60;
endpackage

// ----- src/tick_deadline_alarm_queues.sv -----
// Tick counter with two sorted deadline tables walked by one sequencer.
// A signal set that finds a pending alarm converts its remaining ticks back to seconds
// with a 32-step divide before the new deadline is inserted.
// A tick emits fired entries one per cycle while the output is not stalled, then a tick-done result.
// One request at a time; s_ready is low until the last result is registered.
// Synchronous active-low reset clears the tick count and both tables.
module tick_deadline_alarm_queues #(
    parameter int WATCH_DEPTH  = 16,
    parameter int SIGNAL_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_requester,
    input  logic [3:0]  s_watch_kind,
    input  logic [15:0] s_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_who,
    output logic [3:0]  m_fired_kind,
    output logic [31:0] m_value,
    output logic        m_last
);
    localparam int WIW = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;
    localparam int SIW = (SIGNAL_DEPTH > 1) ? $clog2(SIGNAL_DEPTH) : 1;
    localparam int WCW = $clog2(WATCH_DEPTH + 1);
    localparam int SCW = $clog2(SIGNAL_DEPTH + 1);
    localparam logic [WCW-1:0] WFULL = WCW'(WATCH_DEPTH);
    localparam logic [SCW-1:0] SFULL = SCW'(SIGNAL_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_WPOP, S_SPOP, S_EMIT,
        S_WSCAN, S_WDEC, S_WPOS, S_WINS,
        S_SSCAN, S_DIV, S_SDEC, S_SPOS, S_SINS
    } state_t;

    state_t state_reg;
    logic [9:0]  tps_reg;
    logic [31:0] tick_reg;
    logic [31:0] wdl_reg [WATCH_DEPTH];
    logic [7:0]  wown_reg [WATCH_DEPTH];
    logic [3:0]  wty_reg [WATCH_DEPTH];
    logic [WCW-1:0] wused_reg, wi_reg;
    logic [31:0] sdl_reg [SIGNAL_DEPTH];
    logic [7:0]  sown_reg [SIGNAL_DEPTH];
    logic [SCW-1:0] sused_reg, si_reg;
    logic [7:0]  who_reg;
    logic [3:0]  wk_reg;
    logic [15:0] amt_reg;
    logic        found_reg;
    logic [31:0] dl_reg, q_reg, old_reg;
    logic [9:0]  rem_reg;
    logic [4:0]  dcnt_reg;
    logic [2:0]  pk_reg;
    logic [31:0] pv_reg;
    logic        mv_reg, ml_reg;
    logic [2:0]  mk_reg;
    logic [7:0]  mw_reg;
    logic [3:0]  mf_reg;
    logic [31:0] mval_reg;

    logic        ofree;
    logic [9:0]  rate;
    logic [10:0] trial;
    logic [WIW-1:0] wix;
    logic [SIW-1:0] six;
    logic [31:0] wdl_i, sdl_i;
    logic        w_due, s_due, out_load;

    assign ofree = !mv_reg || m_ready;
    assign rate  = (tps_reg == 10'd0) ? 10'd1 : tps_reg;
    assign trial = {rem_reg, dl_reg[31]};
    assign wix   = wi_reg[WIW-1:0];
    assign six   = si_reg[SIW-1:0];
    assign wdl_i = wdl_reg[wix];
    assign sdl_i = sdl_reg[six];
    assign w_due = (wused_reg != '0) && (wdl_reg[0] <= tick_reg);
    assign s_due = (sused_reg != '0) && (sdl_reg[0] <= tick_reg);
    assign out_load = ofree && ((state_reg == S_WPOP && w_due) ||
                                (state_reg == S_SPOP && s_due) ||
                                (state_reg == S_EMIT));

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = mv_reg;
    assign m_kind       = mk_reg;
    assign m_who        = mw_reg;
    assign m_fired_kind = mf_reg;
    assign m_value      = mval_reg;
    assign m_last       = ml_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tps_reg   <= tdaq_pkg::TPS_RESET;
            tick_reg  <= '0;
            wused_reg <= '0;
            sused_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tps_reg <= cfg_data;
            end
            mv_reg <= out_load || (mv_reg && !m_ready);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        who_reg   <= s_requester;
                        wk_reg    <= s_watch_kind;
                        amt_reg   <= s_amount;
                        wi_reg    <= '0;
                        si_reg    <= '0;
                        found_reg <= 1'b0;
                        old_reg   <= '0;
                        unique case (s_func)
                            tdaq_pkg::FUNC_TICK: begin
                                tick_reg  <= tick_reg + 32'd1;
                                state_reg <= S_WPOP;
                            end
                            tdaq_pkg::FUNC_SIGNAL: state_reg <= S_SSCAN;
                            tdaq_pkg::FUNC_WATCH:  state_reg <= S_WSCAN;
                            default: begin
                                pk_reg    <= tdaq_pkg::KIND_UPTIME;
                                pv_reg    <= tick_reg;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_WPOP: begin
                    if (w_due) begin
                        if (ofree) begin
                            mk_reg   <= tdaq_pkg::KIND_WATCH_FIRED;
                            mw_reg   <= wown_reg[0];
                            mf_reg   <= wty_reg[0];
                            mval_reg <= '0;
                            ml_reg   <= 1'b0;
                            for (int j = 0; j < WATCH_DEPTH - 1; j++) begin
                                wdl_reg[j]  <= wdl_reg[j+1];
                                wown_reg[j] <= wown_reg[j+1];
                                wty_reg[j]  <= wty_reg[j+1];
                            end
                            wused_reg <= wused_reg - 1'b1;
                        end
                    end else begin
                        state_reg <= S_SPOP;
                    end
                end
                S_SPOP: begin
                    if (s_due) begin
                        if (ofree) begin
                            mk_reg   <= tdaq_pkg::KIND_SIGNAL_FIRED;
                            mw_reg   <= sown_reg[0];
                            mf_reg   <= '0;
                            mval_reg <= '0;
                            ml_reg   <= 1'b0;
                            for (int j = 0; j < SIGNAL_DEPTH - 1; j++) begin
                                sdl_reg[j]  <= sdl_reg[j+1];
                                sown_reg[j] <= sown_reg[j+1];
                            end
                            sused_reg <= sused_reg - 1'b1;
                        end
                    end else begin
                        pk_reg    <= tdaq_pkg::KIND_TICK_DONE;
                        pv_reg    <= tick_reg;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (ofree) begin
                        mk_reg   <= pk_reg;
                        mw_reg   <= (pk_reg == tdaq_pkg::KIND_SET_OK ||
                                     pk_reg == tdaq_pkg::KIND_FULL) ? who_reg : 8'd0;
                        mf_reg   <= '0;
                        mval_reg <= pv_reg;
                        ml_reg   <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_WSCAN: begin
                    if (wi_reg == wused_reg) begin
                        state_reg <= S_WDEC;
                    end else if (wown_reg[wix] == who_reg && wty_reg[wix] == wk_reg) begin
                        for (int j = 0; j < WATCH_DEPTH - 1; j++) begin
                            if (j >= int'(wix)) begin
                                wdl_reg[j]  <= wdl_reg[j+1];
                                wown_reg[j] <= wown_reg[j+1];
                                wty_reg[j]  <= wty_reg[j+1];
                            end
                        end
                        wused_reg <= wused_reg - 1'b1;
                        state_reg <= S_WDEC;
                    end else begin
                        wi_reg <= wi_reg + 1'b1;
                    end
                end
                S_WDEC: begin
                    if (wused_reg >= WFULL) begin
                        pk_reg    <= tdaq_pkg::KIND_FULL;
                        pv_reg    <= '0;
                        state_reg <= S_EMIT;
                    end else begin
                        dl_reg    <= tick_reg + {16'd0, amt_reg};
                        wi_reg    <= '0;
                        state_reg <= S_WPOS;
                    end
                end
                S_WPOS: begin
                    if (wi_reg == wused_reg || wdl_i > dl_reg) begin
                        state_reg <= S_WINS;
                    end else begin
                        wi_reg <= wi_reg + 1'b1;
                    end
                end
                S_WINS: begin
                    for (int j = 0; j < WATCH_DEPTH; j++) begin
                        if (j == int'(wix)) begin
                            wdl_reg[j]  <= dl_reg;
                            wown_reg[j] <= who_reg;
                            wty_reg[j]  <= wk_reg;
                        end else if (j > int'(wix)) begin
                            wdl_reg[j]  <= wdl_reg[j-1];
                            wown_reg[j] <= wown_reg[j-1];
                            wty_reg[j]  <= wty_reg[j-1];
                        end
                    end
                    wused_reg <= wused_reg + 1'b1;
                    pk_reg    <= tdaq_pkg::KIND_SET_OK;
                    pv_reg    <= '0;
                    state_reg <= S_EMIT;
                end
                S_SSCAN: begin
                    if (si_reg == sused_reg) begin
                        state_reg <= S_SDEC;
                    end else if (sown_reg[six] == who_reg) begin
                        dl_reg    <= sdl_i - tick_reg;
                        for (int j = 0; j < SIGNAL_DEPTH - 1; j++) begin
                            if (j >= int'(six)) begin
                                sdl_reg[j]  <= sdl_reg[j+1];
                                sown_reg[j] <= sown_reg[j+1];
                            end
                        end
                        sused_reg <= sused_reg - 1'b1;
                        found_reg <= 1'b1;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        si_reg <= si_reg + 1'b1;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (trial >= {1'b0, rate}) begin
                        rem_reg <= 10'(trial - {1'b0, rate});
                        q_reg   <= {q_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= trial[9:0];
                        q_reg   <= {q_reg[30:0], 1'b0};
                    end
                    dl_reg   <= {dl_reg[30:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd31) begin
                        state_reg <= S_SDEC;
                    end
                end
                S_SDEC: begin
                    logic [31:0] oldv;
                    oldv = found_reg ? (q_reg + {31'd0, rem_reg != 10'd0}) : 32'd0;
                    old_reg <= oldv;
                    if (amt_reg == 16'd0) begin
                        pk_reg    <= tdaq_pkg::KIND_SET_OK;
                        pv_reg    <= oldv;
                        state_reg <= S_EMIT;
                    end else if (!found_reg && sused_reg >= SFULL) begin
                        pk_reg    <= tdaq_pkg::KIND_FULL;
                        pv_reg    <= '0;
                        state_reg <= S_EMIT;
                    end else begin
                        dl_reg    <= tick_reg + ({16'd0, amt_reg} * {22'd0, rate});
                        si_reg    <= '0;
                        state_reg <= S_SPOS;
                    end
                end
                S_SPOS: begin
                    if (si_reg == sused_reg || sdl_i > dl_reg) begin
                        state_reg <= S_SINS;
                    end else begin
                        si_reg <= si_reg + 1'b1;
                    end
                end
                S_SINS: begin
                    for (int j = 0; j < SIGNAL_DEPTH; j++) begin
                        if (j == int'(six)) begin
                            sdl_reg[j]  <= dl_reg;
                            sown_reg[j] <= who_reg;
                        end else if (j > int'(six)) begin
                            sdl_reg[j]  <= sdl_reg[j-1];
                            sown_reg[j] <= sown_reg[j-1];
                        end
                    end
                    sused_reg <= sused_reg + 1'b1;
                    pk_reg    <= tdaq_pkg::KIND_SET_OK;
                    pv_reg    <= old_reg;
                    state_reg <= S_EMIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_wused: assert property (@(posedge aclk) disable iff (!aresetn)
        wused_reg <= WFULL) else $error("watch count overflow");
    a_sused: assert property (@(posedge aclk) disable iff (!aresetn)
        sused_reg <= SFULL) else $error("signal count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("accepted while busy");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(m_valid && m_last) || $past(m_valid && !m_ready))
        else $error("early last");
endmodule

// ----- test/tdaq_checker.sv -----
// Checker for the tick deadline alarm queues: predicts results and compares them.
module tdaq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_requester,
    input  logic [3:0]  s_watch_kind,
    input  logic [15:0] s_amount,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [7:0]  m_who,
    input  logic [3:0]  m_fired_kind,
    input  logic [31:0] m_value,
    input  logic        m_last,
    output int          errors,
    output int          pending
);
    localparam int WDEPTH = 16;
    localparam int SDEPTH = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  who;
        logic [3:0]  fired_kind;
        logic [31:0] value;
        logic        last;
    } alarm_result_t;

    alarm_result_t alarm_q[$];
    logic [9:0]  tps;
    logic [31:0] ticks;
    logic [31:0] w_dl [WDEPTH];
    logic [7:0]  w_own [WDEPTH];
    logic [3:0]  w_typ [WDEPTH];
    int          w_used;
    logic [31:0] s_dl [SDEPTH];
    logic [7:0]  s_own [SDEPTH];
    int          s_used;
    int          err_n = 0;

    task automatic watch_drop(int i);
        for (int j = i; j + 1 < w_used; j++) begin
            w_dl[j] = w_dl[j+1]; w_own[j] = w_own[j+1]; w_typ[j] = w_typ[j+1];
        end
        w_used--;
    endtask

    task automatic signal_drop(int i);
        for (int j = i; j + 1 < s_used; j++) begin
            s_dl[j] = s_dl[j+1]; s_own[j] = s_own[j+1];
        end
        s_used--;
    endtask

    task automatic predict_alarms(logic [1:0] func, logic [7:0] req, logic [3:0] wk,
                                  logic [15:0] amt);
        alarm_result_t batch[$];
        logic [31:0] r, old, diff, dl;
        bit found;
        int pos;
        found = 0;
        old = '0;
        r = (tps == 0) ? 32'd1 : {22'd0, tps};
        case (func)
            tdaq_pkg::FUNC_TICK: begin
                ticks = ticks + 1;
                while (w_used > 0 && w_dl[0] <= ticks) begin
                    batch.push_back('{tdaq_pkg::KIND_WATCH_FIRED, w_own[0], w_typ[0],
                                      32'd0, 1'b0});
                    watch_drop(0);
                end
                while (s_used > 0 && s_dl[0] <= ticks) begin
                    batch.push_back('{tdaq_pkg::KIND_SIGNAL_FIRED, s_own[0], 4'd0,
                                      32'd0, 1'b0});
                    signal_drop(0);
                end
                batch.push_back('{tdaq_pkg::KIND_TICK_DONE, 8'd0, 4'd0, ticks, 1'b0});
            end
            tdaq_pkg::FUNC_SIGNAL: begin
                for (int i = 0; i < s_used; i++) begin
                    if (s_own[i] == req) begin
                        diff = s_dl[i] - ticks;
                        old = diff / r + ((diff % r) != 0 ? 32'd1 : 32'd0);
                        signal_drop(i);
                        found = 1;
                        break;
                    end
                end
                if (amt == 0) begin
                    batch.push_back('{tdaq_pkg::KIND_SET_OK, req, 4'd0, old, 1'b0});
                end else if (!found && s_used >= SDEPTH) begin
                    batch.push_back('{tdaq_pkg::KIND_FULL, req, 4'd0, 32'd0, 1'b0});
                end else begin
                    dl = ticks + {16'd0, amt} * r;
                    pos = 0;
                    while (pos < s_used && s_dl[pos] <= dl) pos++;
                    for (int j = s_used; j > pos; j--) begin
                        s_dl[j] = s_dl[j-1]; s_own[j] = s_own[j-1];
                    end
                    s_dl[pos] = dl; s_own[pos] = req; s_used++;
                    batch.push_back('{tdaq_pkg::KIND_SET_OK, req, 4'd0, old, 1'b0});
                end
            end
            tdaq_pkg::FUNC_WATCH: begin
                for (int i = 0; i < w_used; i++) begin
                    if (w_own[i] == req && w_typ[i] == wk) begin
                        watch_drop(i);
                        found = 1;
                        break;
                    end
                end
                if (!found && w_used >= WDEPTH) begin
                    batch.push_back('{tdaq_pkg::KIND_FULL, req, 4'd0, 32'd0, 1'b0});
                end else begin
                    dl = ticks + {16'd0, amt};
                    pos = 0;
                    while (pos < w_used && w_dl[pos] <= dl) pos++;
                    for (int j = w_used; j > pos; j--) begin
                        w_dl[j] = w_dl[j-1]; w_own[j] = w_own[j-1]; w_typ[j] = w_typ[j-1];
                    end
                    w_dl[pos] = dl; w_own[pos] = req; w_typ[pos] = wk; w_used++;
                    batch.push_back('{tdaq_pkg::KIND_SET_OK, req, 4'd0, 32'd0, 1'b0});
                end
            end
            default: batch.push_back('{tdaq_pkg::KIND_UPTIME, 8'd0, 4'd0, ticks, 1'b0});
        endcase
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) alarm_q.push_back(batch[i]);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            err_n++;
        end
    endtask

    always @(posedge aclk) begin
        alarm_result_t e;
        if (!aresetn) begin
            tps = tdaq_pkg::TPS_RESET;
            ticks = '0;
            w_used = 0;
            s_used = 0;
            alarm_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (alarm_q.size() == 0) begin
                    $error("unexpected result: kind %0d who %0d", m_kind, m_who);
                    err_n++;
                end else begin
                    e = alarm_q.pop_front();
                    check_field("kind", e.kind, m_kind);
                    check_field("who", e.who, m_who);
                    check_field("fired_kind", e.fired_kind, m_fired_kind);
                    check_field("value", e.value, m_value);
                    check_field("last", e.last, m_last);
                end
            end
            if (cfg_valid && cfg_ready) tps = cfg_data;
            if (s_valid && s_ready)
                predict_alarms(s_func, s_requester, s_watch_kind, s_amount);
        end
        errors  <= err_n;
        pending <= alarm_q.size();
    end
endmodule

// ----- test/tb_tick_deadline_alarm_queues.sv -----
// Testbench top for the tick deadline alarm queues: stimulus, handshake pacing and verdict.
module tb_tick_deadline_alarm_queues;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = tdaq_pkg::FUNC_UPTIME;
    logic [7:0]  s_requester = '0;
    logic [3:0]  s_watch_kind = '0;
    logic [15:0] s_amount = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_who;
    logic [3:0]  m_fired_kind;
    logic [31:0] m_value;
    logic        m_last;
    int          errors, pending;
    int          cycles = 0;
    int          burst_left = 0;
    int          hold_cnt = 0;
    logic        hold_go = 1'b0;
    bit          hold_used = 0;
    int          n_req = 0;

    localparam int LIMIT = 400000;

    always #10 aclk = ~aclk;

    tick_deadline_alarm_queues u_top (.*);

    tdaq_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_tick_deadline_alarm_queues NOT OK");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise alternating free and random stretches
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used = 1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if ((cycles / 64) % 2 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 6);
        end
    end

    task automatic send(logic [1:0] f, logic [7:0] r, logic [3:0] k, logic [15:0] a);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_requester <= r;
        s_watch_kind <= k;
        s_amount <= a;
        do @(posedge aclk); while (!s_ready);
        n_req++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_rate(logic [9:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int n);
        int sel;
        logic [15:0] a;
        logic [7:0] r;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            r = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
            if (sel < 35) begin
                send(tdaq_pkg::FUNC_TICK, 8'($urandom), 4'($urandom), 16'($urandom));
            end else if (sel < 70) begin
                a = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
                send(tdaq_pkg::FUNC_WATCH, r, 4'($urandom_range(0, 3)), a);
            end else if (sel < 92) begin
                a = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
                send(tdaq_pkg::FUNC_SIGNAL, r, 4'($urandom), a);
            end else begin
                send(tdaq_pkg::FUNC_UPTIME, 8'($urandom), 4'($urandom), 16'($urandom));
            end
            if (i == n / 2 && !hold_used) hold_go <= 1'b1;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(tdaq_pkg::FUNC_UPTIME, 8'd0, 4'd0, 16'd0);
        write_rate(10'd1);
        send(tdaq_pkg::FUNC_WATCH, 8'd255, 4'd15, 16'd65535);
        send(tdaq_pkg::FUNC_SIGNAL, 8'd255, 4'd15, 16'd65535);
        for (int i = 0; i < 16; i++) send(tdaq_pkg::FUNC_WATCH, 8'(i), 4'(i), 16'd1);
        for (int i = 0; i < 16; i++) send(tdaq_pkg::FUNC_SIGNAL, 8'(i), 4'd0, 16'd1);
        send(tdaq_pkg::FUNC_SIGNAL, 8'd200, 4'd0, 16'd0);
        send(tdaq_pkg::FUNC_WATCH, 8'd255, 4'd15, 16'd0);
        send(tdaq_pkg::FUNC_SIGNAL, 8'd255, 4'd0, 16'd0);
        send(tdaq_pkg::FUNC_SIGNAL, 8'd77, 4'd0, 16'd1);
        send(tdaq_pkg::FUNC_SIGNAL, 8'd3, 4'd0, 16'd0);
        send(tdaq_pkg::FUNC_TICK, 8'd0, 4'd0, 16'd0);
        send(tdaq_pkg::FUNC_UPTIME, 8'd255, 4'd15, 16'hFFFF);

        write_rate(10'd7);
        random_requests(50);
        drain();
        random_requests(15);
        write_rate(10'd1000);
        random_requests(40);
        write_rate(10'd0);
        random_requests(40);
        write_rate(10'd60);
        random_requests(43);
        drain();

        $display("run covered %0d requests over tick rates 1, 7, 1000, 0 and 60",
                 n_req);
        if (errors == 0) begin
            $display("tb_tick_deadline_alarm_queues OK");
        end else begin
            $display("tb_tick_deadline_alarm_queues NOT OK");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/tdaq_pkg.sv
src/tick_deadline_alarm_queues.sv
test/tdaq_checker.sv
test/tb_tick_deadline_alarm_queues.sv
